[rtl/core/spsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spsc_pkg;
  localparam int ENTRY_LENGTH_DEF = 13;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
  localparam logic [7:0] NEWLINE = 8'h0a;
  localparam int NUM_REGS = 5;
  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_DIGEST0 = 3'd1;
  localparam logic [2:0] REG_DIGEST1 = 3'd2;
  localparam logic [2:0] REG_DIGEST2 = 3'd3;
  localparam logic [2:0] REG_DIGEST3 = 3'd4;

  typedef struct packed {
    logic load;   // copy entry into the message schedule and init state
    logic round;  // run one compression round
    logic finish; // add the initial value into the state
  } hash_cmd_t;

  typedef struct packed {
    logic last_round;
  } hash_sts_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
endpackage
`default_nettype wire

[rtl/core/spsc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface spsc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] rx_byte;
  modport source (output valid, cmd, rx_byte, input ready);
  modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface spsc_out_if;
  logic valid;
  logic ready;
  logic entry_checked;
  logic matched;
  logic unlocked;
  logic [3:0] fill_count;
  modport source (output valid, entry_checked, matched, unlocked, fill_count, input ready);
  modport sink (input valid, entry_checked, matched, unlocked, fill_count, output ready);
endinterface
`default_nettype wire

[rtl/core/spsc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module spsc_datapath #(
  parameter int ENTRY_LENGTH = spsc_pkg::ENTRY_LENGTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic [ENTRY_LENGTH*8-1:0] entry,
  input  wire spsc_pkg::hash_cmd_t       cmd,
  output spsc_pkg::hash_sts_t            sts,
  output logic [255:0]                   digest
);
  localparam logic [63:0] BITLEN = 64'(ENTRY_LENGTH * 8);

  logic [31:0] w [16];
  logic [31:0] s [8];
  logic [5:0]  rnd;
  logic [511:0] blk;
  logic [31:0] s0, s1, wn, t1, t2, e, a;

  always_comb begin
    blk = '0;
    blk[511 -: ENTRY_LENGTH*8] = entry;
    blk[511 - ENTRY_LENGTH*8 -: 8] = 8'h80;
    blk[63:0] = BITLEN;
  end

  assign s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign wn = w[0] + s0 + w[9] + s1;
  assign e = s[4];
  assign a = s[0];
  assign t1 = s[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & s[5]) ^ (~e & s[6])) + spsc_pkg::RK[rnd] + w[0];
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & s[1]) ^ (a & s[2]) ^ (s[1] & s[2]));

  assign sts.last_round = (rnd == 6'd63);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) s[i] <= spsc_pkg::IV[i];
      rnd <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      s[7] <= s[6]; s[6] <= s[5]; s[5] <= s[4]; s[4] <= s[3] + t1;
      s[3] <= s[2]; s[2] <= s[1]; s[1] <= s[0]; s[0] <= t1 + t2;
      rnd <= rnd + 6'd1;
    end else if (cmd.finish) begin
      for (int i = 0; i < 8; i++) s[i] <= s[i] + spsc_pkg::IV[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = s[i];
  end
endmodule
`default_nettype wire

[rtl/core/spsc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module spsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire spsc_pkg::hash_sts_t sts,
  output spsc_pkg::hash_cmd_t      cmd,
  output logic                     busy,
  output logic                     done
);
  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINISH, S_DONE} state_t;
  state_t state;

  always_comb begin
    cmd.load = start && state == S_IDLE;
    cmd.round = state == S_ROUND;
    cmd.finish = state == S_FINISH;
  end
  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (start) state <= S_ROUND;
        S_ROUND:  if (sts.last_round) state <= S_FINISH;
        S_FINISH: state <= S_DONE;
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/serial_passphrase_sha256_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// results: byte or tick beats give a result the next cycle; the byte that
// completes an entry starts the hash instead: a load, 64 rounds of one shared
// round unit, a finalize add, then a compare whose result is registered
// throughput: one beat per cycle when the output is not stalled; none while a hash runs
// reset: synchronous active high; clears fill, idle count and unlocked; config goes to its defaults
module serial_passphrase_sha256_checker #(
  parameter int ENTRY_LENGTH = spsc_pkg::ENTRY_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  spsc_in_if.sink          in_ch,
  spsc_out_if.source       out_ch
);
  localparam int FW = $clog2(ENTRY_LENGTH + 1);
  localparam int IW = (ENTRY_LENGTH > 1) ? $clog2(ENTRY_LENGTH) : 1;

  // configuration
  logic [15:0]  timeout_ticks;
  logic [255:0] expected;

  // entry state
  logic [7:0]    entry_store [ENTRY_LENGTH];
  logic [FW-1:0] fill_index;
  logic [15:0]   idle_ticks;
  logic          unlocked_flag;

  logic [ENTRY_LENGTH*8-1:0] entry_flat;
  spsc_pkg::hash_cmd_t hcmd;
  spsc_pkg::hash_sts_t hsts;
  logic [255:0] digest;
  logic start, busy, done;

  logic accept;
  logic is_byte, is_tick, last_byte;
  logic [15:0] idle_inc;

  assign in_ch.ready = !busy && !start && (!out_ch.valid || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign is_tick = in_ch.cmd;
  assign is_byte = !in_ch.cmd && in_ch.rx_byte != spsc_pkg::NEWLINE;
  assign last_byte = fill_index == FW'(ENTRY_LENGTH - 1);
  assign idle_inc = (idle_ticks == 16'hffff) ? idle_ticks : idle_ticks + 16'd1;

  always_comb begin
    for (int i = 0; i < ENTRY_LENGTH; i++) entry_flat[ENTRY_LENGTH*8-1 - 8*i -: 8] = entry_store[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= spsc_pkg::TIMEOUT_RESET;
      expected <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spsc_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        spsc_pkg::REG_DIGEST0: expected[255:192] <= cfg_data;
        spsc_pkg::REG_DIGEST1: expected[191:128] <= cfg_data;
        spsc_pkg::REG_DIGEST2: expected[127:64] <= cfg_data;
        spsc_pkg::REG_DIGEST3: expected[63:0] <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && is_byte) entry_store[fill_index[IW-1:0]] <= in_ch.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index <= '0;
      idle_ticks <= '0;
      unlocked_flag <= 1'b0;
      start <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (accept) begin
        if (is_tick) begin
          idle_ticks <= idle_inc;
          if (fill_index != '0 && idle_inc > timeout_ticks) fill_index <= '0;
        end else begin
          idle_ticks <= '0;
          if (!is_byte) fill_index <= '0;
          else if (last_byte) fill_index <= '0;
          else fill_index <= fill_index + FW'(1);
        end
        // full entry: result comes after the hash
        if (is_byte && last_byte) begin
          start <= 1'b1;
        end else begin
          out_ch.valid <= 1'b1;
          out_ch.entry_checked <= 1'b0;
          out_ch.matched <= 1'b0;
          out_ch.unlocked <= unlocked_flag;
          out_ch.fill_count <= 4'(is_tick ? ((fill_index != '0 && idle_inc > timeout_ticks)
                                 ? '0 : fill_index) : (is_byte ? fill_index + FW'(1) : '0));
        end
      end
      // compare finished digest
      if (done) begin
        out_ch.valid <= 1'b1;
        out_ch.entry_checked <= 1'b1;
        out_ch.matched <= digest == expected;
        out_ch.unlocked <= unlocked_flag || (digest == expected);
        out_ch.fill_count <= '0;
        if (digest == expected) unlocked_flag <= 1'b1;
      end
    end
  end

  spsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(hsts), .cmd(hcmd), .busy(busy), .done(done)
  );

  spsc_datapath #(.ENTRY_LENGTH(ENTRY_LENGTH)) u_dp (
    .clk(clk), .entry(entry_flat), .cmd(hcmd), .sts(hsts), .digest(digest)
  );
endmodule
`default_nettype wire
